>>> design/integer_pixel_replication_upscaler_assert.svh
// Assertion macros shared by the upscaler modules.
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define IPRU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("upscaler assertion failed");
`define IPRU_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("upscaler assertion failed");
`else
`define IPRU_ASSERT(label, clk, rst, prop)
`define IPRU_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

>>> design/ipru_pkg.sv
package ipru_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int WIDTH_LIMIT       = 4095;

   localparam int SCALE_BITS = 7;
   localparam int WIDTH_BITS = 12;
   localparam int ROWS_BITS  = 17;
   localparam int CSR_BITS   = 17;
   localparam int INDEX_BITS = 2;
   localparam int PIXEL_BITS = 24;

   localparam logic [SCALE_BITS-1:0] SCALE_MAX = 7'd64;
   localparam logic [ROWS_BITS-1:0]  ROWS_MAX  = 17'd65536;

   localparam logic [INDEX_BITS-1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [INDEX_BITS-1:0] CSR_ROW_WIDTH    = 2'd1;
   localparam logic [INDEX_BITS-1:0] CSR_ROW_TOTAL    = 2'd2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_PULL = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_PAD   = 1'b1;

   typedef struct packed {
      logic [SCALE_BITS-1:0] scale;
      logic [WIDTH_BITS-1:0] width;
      logic [ROWS_BITS-1:0]  rows;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic kind;
      logic eol;
      logic eof;
   } result_ctl_type;

endpackage

>>> design/ipru_csr.sv
module ipru_csr #(
   parameter int MAX_WIDTH = ipru_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ipru_pkg::INDEX_BITS-1:0] csr_index,
   input  logic [ipru_pkg::CSR_BITS-1:0]   csr_data,
   output ipru_pkg::cfg_type               cfg
);
   import ipru_pkg::*;

   localparam int DEPTH = (MAX_WIDTH > WIDTH_LIMIT) ? WIDTH_LIMIT : MAX_WIDTH;
   localparam logic [WIDTH_BITS-1:0] DEPTH_W = WIDTH_BITS'(DEPTH);

   logic [SCALE_BITS-1:0] scale_ff;
   logic [WIDTH_BITS-1:0] width_ff;
   logic [ROWS_BITS-1:0]  rows_ff;
   logic                  write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_BITS'(1);
         width_ff <= WIDTH_BITS'(1);
         rows_ff  <= ROWS_BITS'(1);
      end else if (write) begin
         case (csr_index)
            CSR_SCALE_FACTOR: scale_ff <= csr_data[SCALE_BITS-1:0];
            CSR_ROW_WIDTH:    width_ff <= csr_data[WIDTH_BITS-1:0];
            CSR_ROW_TOTAL:    rows_ff  <= csr_data[ROWS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg = '0;
      if (scale_ff == '0) cfg.scale = SCALE_BITS'(1);
      else if (scale_ff > SCALE_MAX) cfg.scale = SCALE_MAX;
      else cfg.scale = scale_ff;
      if (width_ff == '0) cfg.width = WIDTH_BITS'(1);
      else if (width_ff > DEPTH_W) cfg.width = DEPTH_W;
      else cfg.width = width_ff;
      if (rows_ff == '0) cfg.rows = ROWS_BITS'(1);
      else if (rows_ff > ROWS_MAX) cfg.rows = ROWS_MAX;
      else cfg.rows = rows_ff;
   end

endmodule

>>> design/ipru_line_store.sv
module ipru_line_store #(
   parameter int  MAX_WIDTH = ipru_pkg::MAX_WIDTH_DEFAULT,
   localparam int DEPTH     = (MAX_WIDTH > ipru_pkg::WIDTH_LIMIT) ?
                              ipru_pkg::WIDTH_LIMIT : MAX_WIDTH,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_BITS-1:0]            wr_addr,
   input  logic [ipru_pkg::PIXEL_BITS-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [ADDR_BITS-1:0]            rd_addr,
   output logic [ipru_pkg::PIXEL_BITS-1:0] rd_data
);
   import ipru_pkg::*;

   logic [PIXEL_BITS-1:0] mem [DEPTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ipru_ctrl.sv
`include "integer_pixel_replication_upscaler_assert.svh"

module ipru_ctrl #(
   parameter int  MAX_WIDTH = ipru_pkg::MAX_WIDTH_DEFAULT,
   localparam int DEPTH     = (MAX_WIDTH > ipru_pkg::WIDTH_LIMIT) ?
                              ipru_pkg::WIDTH_LIMIT : MAX_WIDTH,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ipru_pkg::cfg_type        cfg,
   input  logic                     accept,
   input  logic                     mode,
   output logic                     wr_en,
   output logic [ADDR_BITS-1:0]     wr_addr,
   output logic                     rd_en,
   output logic [ADDR_BITS-1:0]     rd_addr,
   output ipru_pkg::result_ctl_type res
);
   import ipru_pkg::*;

   logic [WIDTH_BITS-1:0] stored_count_ff, stored_count_in;
   logic [WIDTH_BITS-1:0] read_column_ff, read_column_in;
   logic [SCALE_BITS-1:0] column_repeat_ff, column_repeat_in;
   logic [SCALE_BITS-1:0] row_repeat_ff, row_repeat_in;
   logic [1:0]            pad_left_ff, pad_left_in;
   logic [15:0]           row_index_ff, row_index_in;

   logic [SCALE_BITS-1:0] row_repeat_inc;
   logic [ROWS_BITS-1:0]  row_index_inc;
   logic [SCALE_BITS-1:0] column_repeat_inc;
   logic [WIDTH_BITS-1:0] read_column_inc;
   logic [1:0]            pad;
   logic                  last_row;
   logic                  finish;

   assign row_repeat_inc    = row_repeat_ff + SCALE_BITS'(1);
   assign row_index_inc     = {1'b0, row_index_ff} + ROWS_BITS'(1);
   assign column_repeat_inc = column_repeat_ff + SCALE_BITS'(1);
   assign read_column_inc   = read_column_ff + WIDTH_BITS'(1);
   assign pad               = cfg.width[1:0] * cfg.scale[1:0];
   assign last_row          = (row_repeat_inc >= cfg.scale) && (row_index_inc >= cfg.rows);
   assign wr_addr           = stored_count_ff[ADDR_BITS-1:0];
   assign rd_addr           = read_column_ff[ADDR_BITS-1:0];

   always_comb begin
      stored_count_in  = stored_count_ff;
      read_column_in   = read_column_ff;
      column_repeat_in = column_repeat_ff;
      row_repeat_in    = row_repeat_ff;
      pad_left_in      = pad_left_ff;
      row_index_in     = row_index_ff;
      res              = '0;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      finish           = 1'b0;
      if (accept) begin
         if (mode == MODE_PUSH) begin
            if (stored_count_ff < cfg.width) begin
               wr_en           = 1'b1;
               stored_count_in = stored_count_ff + WIDTH_BITS'(1);
            end
         end else if (pad_left_ff != 2'd0) begin
            res.valid   = 1'b1;
            res.kind    = KIND_PAD;
            pad_left_in = pad_left_ff - 2'd1;
            if (pad_left_ff == 2'd1) begin
               res.eol = 1'b1;
               res.eof = last_row;
               finish  = 1'b1;
            end
         end else if (read_column_ff >= cfg.width) begin
            finish = 1'b1;
         end else if (read_column_ff < stored_count_ff) begin
            res.valid = 1'b1;
            res.kind  = KIND_PIXEL;
            rd_en     = 1'b1;
            if (column_repeat_inc >= cfg.scale) begin
               column_repeat_in = '0;
               if (read_column_inc >= cfg.width) begin
                  read_column_in = '0;
                  if (pad != 2'd0) begin
                     pad_left_in = pad;
                  end else begin
                     res.eol = 1'b1;
                     res.eof = last_row;
                     finish  = 1'b1;
                  end
               end else begin
                  read_column_in = read_column_inc;
               end
            end else begin
               column_repeat_in = column_repeat_inc;
            end
         end
      end
      if (finish) begin
         read_column_in   = '0;
         column_repeat_in = '0;
         pad_left_in      = 2'd0;
         row_repeat_in    = row_repeat_inc;
         if (row_repeat_inc >= cfg.scale) begin
            row_repeat_in   = '0;
            stored_count_in = '0;
            if (row_index_inc >= cfg.rows) row_index_in = '0;
            else row_index_in = row_index_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff  <= '0;
         read_column_ff   <= '0;
         column_repeat_ff <= '0;
         row_repeat_ff    <= '0;
         pad_left_ff      <= 2'd0;
         row_index_ff     <= '0;
      end else begin
         stored_count_ff  <= stored_count_in;
         read_column_ff   <= read_column_in;
         column_repeat_ff <= column_repeat_in;
         row_repeat_ff    <= row_repeat_in;
         pad_left_ff      <= pad_left_in;
         row_index_ff     <= row_index_in;
      end
   end

   `IPRU_ASSERT(a_pad_at_row_start, clock, reset, (pad_left_ff != 2'd0) |-> (read_column_ff == '0))
   `IPRU_ASSERT(a_store_bound, clock, reset, stored_count_ff <= WIDTH_BITS'(DEPTH))
   `IPRU_ASSERT(a_repeat_bound, clock, reset, column_repeat_ff < SCALE_MAX)

endmodule

>>> design/integer_pixel_replication_upscaler.sv
// Integer pixel replication upscaler.
// req_ channel: req_mode 0 pushes req_pixel_in into the one-row line store,
// req_mode 1 pulls the next output item. An item is taken when req_valid is
// high and req_stall is low. Pushes and empty pulls produce no result.
// rsp_ channel: one item per productive pull, a pixel or a zero padding pixel,
// flagged with end_of_line and end_of_frame; taken when rsp_valid is high and
// rsp_stall is low.
// csr_ channel: scale_factor (0), row_width (1), row_total (2); csr_ready is
// always high. Write only while the block is idle.
// Throughput is one item per cycle while rsp_stall is low. A pull's result is
// registered in the line store read and the read stage, then in the output
// register.
// When rsp_stall holds the output register, one more result parks in the read
// stage; req_stall rises only once both are full.
// Synchronous reset clears all counters and the two result stages and sets
// the registers to 1. The line store needs no clearing pass.
`include "integer_pixel_replication_upscaler_assert.svh"

module integer_pixel_replication_upscaler #(
   parameter int MAX_WIDTH = ipru_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [ipru_pkg::PIXEL_BITS-1:0] req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_out_kind,
   output logic [ipru_pkg::PIXEL_BITS-1:0] rsp_out_pixel,
   output logic                            rsp_end_of_line,
   output logic                            rsp_end_of_frame,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ipru_pkg::INDEX_BITS-1:0] csr_index,
   input  logic [ipru_pkg::CSR_BITS-1:0]   csr_data
);
   import ipru_pkg::*;

   localparam int DEPTH     = (MAX_WIDTH > WIDTH_LIMIT) ? WIDTH_LIMIT : MAX_WIDTH;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type               cfg;
   result_ctl_type        res;
   logic                  accept;
   logic                  wr_en;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [PIXEL_BITS-1:0] rd_data;

   result_ctl_type        read_stage_ff;
   logic                  out_valid_ff;
   logic                  out_kind_ff;
   logic [PIXEL_BITS-1:0] out_pixel_ff;
   logic                  out_eol_ff;
   logic                  out_eof_ff;
   logic                  out_load;
   logic                  read_free;

   assign out_load  = read_stage_ff.valid && (!out_valid_ff || !rsp_stall);
   assign read_free = !read_stage_ff.valid || out_load;
   assign req_stall = !read_free;
   assign accept    = req_valid && !req_stall;

   ipru_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipru_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .mode    (req_mode),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .res     (res)
   );

   ipru_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         read_stage_ff <= '0;
      end else if (read_free) begin
         read_stage_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff  <= read_stage_ff.kind;
         out_pixel_ff <= (read_stage_ff.kind == KIND_PAD) ? '0 : rd_data;
         out_eol_ff   <= read_stage_ff.eol;
         out_eof_ff   <= read_stage_ff.eof;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_out_pixel    = out_pixel_ff;
   assign rsp_end_of_line  = out_eol_ff;
   assign rsp_end_of_frame = out_eof_ff;

   `IPRU_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> (read_stage_ff.valid && out_valid_ff && rsp_stall))
   `IPRU_ASSERT(a_pad_is_zero, clock, reset, (rsp_valid && rsp_out_kind == KIND_PAD) |-> (rsp_out_pixel == '0))
   `IPRU_ASSERT(a_eof_on_eol, clock, reset, (rsp_valid && rsp_end_of_frame) |-> rsp_end_of_line)
   `IPRU_ASSERT_NEXT(a_read_moves_on, clock, reset, out_load, out_valid_ff)

endmodule
